>>> rtl/power_key_gesture_detector_unit_assert.svh
// ============================================================================
// Power key gesture detector assertion macros
// Shared property forms for the checks at the end of the top level. Each
// macro samples on clk and is disabled while rst_n is low.
// ============================================================================
`ifndef POWER_KEY_GESTURE_DETECTOR_UNIT_ASSERT_SVH
`define POWER_KEY_GESTURE_DETECTOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PKGD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("power key gesture detector: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PKGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("power key gesture detector: next-cycle check failed");

`endif

>>> rtl/pkgd_pkg.sv
// ============================================================================
// Power key gesture detector package
// Register widths, register indexes, reset values and event codes.
// ============================================================================
`timescale 1ns / 1ps

package pkgd_pkg;

    // Configuration register width and index width.
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_W-1:0]     cfg_word_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    // Register indexes.
    localparam cfg_index_t REG_DEBOUNCE      = 3'd0;
    localparam cfg_index_t REG_TAP_MAX       = 3'd1;
    localparam cfg_index_t REG_LONG_PRESS    = 3'd2;
    localparam cfg_index_t REG_FORCE_OFF     = 3'd3;
    localparam cfg_index_t REG_STABLE_RELEASE = 3'd4;

    // Register reset values in microseconds.
    localparam cfg_word_t DEBOUNCE_RST       = 24'd40000;
    localparam cfg_word_t TAP_MAX_RST        = 24'd800000;
    localparam cfg_word_t LONG_PRESS_RST     = 24'd3000000;
    localparam cfg_word_t FORCE_OFF_RST      = 24'd8000000;
    localparam cfg_word_t STABLE_RELEASE_RST = 24'd200000;

    // Event codes.
    typedef logic [1:0] event_t;
    localparam event_t EV_TAP   = 2'd0;
    localparam event_t EV_LONG  = 2'd1;
    localparam event_t EV_FORCE = 2'd2;
    localparam event_t EV_SLEEP = 2'd3;

endpackage

>>> rtl/power_key_gesture_detector_unit.sv
// ============================================================================
// Power key gesture detector
// Debounces timestamped power key samples and reports tap, long press,
// forced shutdown and enter-sleep events.
// ============================================================================
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid / in_stall  | key_down, time_us, shutdown_request
//  out     | output    | out_valid / out_stall| event_res
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A sample beat is captured in an input register, evaluated in one pass and
//  its event, if any, lands in the output register; one sample per cycle is
//  sustained while the output register is not full and stalled.
//  The input stalls only while a held sample has an output register in front
//  of it that is full and stalled.
//  Reset is asynchronous, active low; it restores register defaults and the
//  boot gate that waits for a stable release. The config port is always ready.
//
`timescale 1ns / 1ps
`include "power_key_gesture_detector_unit_assert.svh"

module power_key_gesture_detector_unit #(
    parameter int TIME_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Sample channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  key_down,
    input  logic [TIME_BITS-1:0]  time_us,
    input  logic                  shutdown_request,
    // Event channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output pkgd_pkg::event_t      event_res,
    // Configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  pkgd_pkg::cfg_index_t  cfg_index,
    input  pkgd_pkg::cfg_word_t   cfg_data
);

    import pkgd_pkg::*;

    localparam int PAD_W = TIME_BITS - CFG_W;

    typedef logic [TIME_BITS-1:0] stamp_t;

    // Configuration registers.
    cfg_word_t debounce_reg, tap_max_reg, long_press_reg, force_off_reg, stable_reg;

    // Input stage.
    logic   s1_valid_reg;
    logic   s1_key_reg;
    logic   s1_req_reg;
    stamp_t s1_time_reg;

    // Gesture state.
    logic   raw_level_reg, raw_level_next;
    stamp_t raw_edge_time_reg, raw_edge_time_next;
    logic   await_release_reg, await_release_next;
    logic   debounced_level_reg, debounced_level_next;
    stamp_t press_start_time_reg, press_start_time_next;
    logic   long_press_sent_reg, long_press_sent_next;
    logic   shutdown_flag_reg, shutdown_flag_next;
    logic   forced_mode_reg, forced_mode_next;
    logic   release_start_valid_reg, release_start_valid_next;
    stamp_t release_start_time_reg, release_start_time_next;
    logic   asleep_reg, asleep_next;

    // Output stage.
    logic   out_valid_reg, out_valid_next;
    event_t event_reg;

    // Evaluation signals.
    logic   advance;
    logic   res_valid;
    event_t res_code;
    stamp_t edge_t_new;
    stamp_t el_edge;
    stamp_t el_release;
    stamp_t el_tap;
    stamp_t held;
    stamp_t rel_start_sel;
    stamp_t press_start_sel;
    logic   deb_change;

    // Handshake: a held sample moves on whenever the output register can take it.
    assign advance   = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign event_res = event_reg;

    // Configuration register writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RST;
            tap_max_reg    <= TAP_MAX_RST;
            long_press_reg <= LONG_PRESS_RST;
            force_off_reg  <= FORCE_OFF_RST;
            stable_reg     <= STABLE_RELEASE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE:       debounce_reg   <= cfg_data;
                REG_TAP_MAX:        tap_max_reg    <= cfg_data;
                REG_LONG_PRESS:     long_press_reg <= cfg_data;
                REG_FORCE_OFF:      force_off_reg  <= cfg_data;
                REG_STABLE_RELEASE: stable_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Input stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_key_reg  <= key_down;
            s1_time_reg <= time_us;
            s1_req_reg  <= shutdown_request;
        end
    end

    // Time differences, all wrapping at the timestamp width.
    always_comb
    begin
        edge_t_new = (s1_key_reg != raw_level_reg) ? s1_time_reg : raw_edge_time_reg;
        el_edge    = s1_time_reg - edge_t_new;
        deb_change = (s1_key_reg != debounced_level_reg)
                     && (el_edge >= {{PAD_W{1'b0}}, debounce_reg});
        press_start_sel = (deb_change && s1_key_reg) ? edge_t_new : press_start_time_reg;
        held       = s1_time_reg - press_start_sel;
        el_tap     = edge_t_new - press_start_time_reg;
        rel_start_sel = release_start_valid_reg ? release_start_time_reg : s1_time_reg;
        el_release = s1_time_reg - rel_start_sel;
    end

    // One evaluation pass over the held sample.
    always_comb
    begin
        raw_level_next           = raw_level_reg;
        raw_edge_time_next       = raw_edge_time_reg;
        await_release_next       = await_release_reg;
        debounced_level_next     = debounced_level_reg;
        press_start_time_next    = press_start_time_reg;
        long_press_sent_next     = long_press_sent_reg;
        shutdown_flag_next       = shutdown_flag_reg || s1_req_reg;
        forced_mode_next         = forced_mode_reg;
        release_start_valid_next = release_start_valid_reg;
        release_start_time_next  = release_start_time_reg;
        asleep_next              = asleep_reg;
        res_valid                = 1'b0;
        res_code                 = EV_TAP;

        if (asleep_reg)
        begin
            // Asleep: only the shutdown flag keeps tracking.
        end
        else if (forced_mode_reg)
        begin
            // Forced shutdown: wait for a stable release, then sleep once.
            if (s1_key_reg)
            begin
                release_start_valid_next = 1'b0;
            end
            else
            begin
                release_start_valid_next = 1'b1;
                release_start_time_next  = rel_start_sel;
                if (el_release >= {{PAD_W{1'b0}}, stable_reg})
                begin
                    asleep_next = 1'b1;
                    res_valid   = 1'b1;
                    res_code    = EV_SLEEP;
                end
            end
        end
        else
        begin
            raw_level_next     = s1_key_reg;
            raw_edge_time_next = edge_t_new;
            if (await_release_reg)
            begin
                // Boot gate: leave once the key has been released long enough.
                if (!s1_key_reg && (el_edge >= {{PAD_W{1'b0}}, stable_reg}))
                begin
                    await_release_next   = 1'b0;
                    debounced_level_next = 1'b0;
                end
            end
            else
            begin
                if (deb_change)
                begin
                    debounced_level_next = s1_key_reg;
                    if (s1_key_reg)
                    begin
                        press_start_time_next = edge_t_new;
                        long_press_sent_next  = 1'b0;
                    end
                    else if (!long_press_sent_reg
                             && (el_tap <= {{PAD_W{1'b0}}, tap_max_reg})
                             && !shutdown_flag_next)
                    begin
                        res_valid = 1'b1;
                        res_code  = EV_TAP;
                    end
                end

                // Hold timing while the key stays pressed after debounce.
                if (debounced_level_next && s1_key_reg)
                begin
                    if (held >= {{PAD_W{1'b0}}, force_off_reg})
                    begin
                        forced_mode_next         = 1'b1;
                        shutdown_flag_next       = 1'b1;
                        release_start_valid_next = 1'b0;
                        res_valid                = 1'b1;
                        res_code                 = EV_FORCE;
                    end
                    else if ((held >= {{PAD_W{1'b0}}, long_press_reg})
                             && !long_press_sent_next && !shutdown_flag_next)
                    begin
                        long_press_sent_next = 1'b1;
                        res_valid            = 1'b1;
                        res_code             = EV_LONG;
                    end
                end
            end
        end
    end

    // Gesture state registers, updated as each sample leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_level_reg           <= 1'b0;
            raw_edge_time_reg       <= '0;
            await_release_reg       <= 1'b1;
            debounced_level_reg     <= 1'b0;
            press_start_time_reg    <= '0;
            long_press_sent_reg     <= 1'b0;
            shutdown_flag_reg       <= 1'b0;
            forced_mode_reg         <= 1'b0;
            release_start_valid_reg <= 1'b0;
            release_start_time_reg  <= '0;
            asleep_reg              <= 1'b0;
        end
        else if (advance)
        begin
            raw_level_reg           <= raw_level_next;
            raw_edge_time_reg       <= raw_edge_time_next;
            await_release_reg       <= await_release_next;
            debounced_level_reg     <= debounced_level_next;
            press_start_time_reg    <= press_start_time_next;
            long_press_sent_reg     <= long_press_sent_next;
            shutdown_flag_reg       <= shutdown_flag_next;
            forced_mode_reg         <= forced_mode_next;
            release_start_valid_reg <= release_start_valid_next;
            release_start_time_reg  <= release_start_time_next;
            asleep_reg              <= asleep_next;
        end
    end

    // Output register: holds while stalled, else takes the new result.
    always_comb
    begin
        if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = advance && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            event_reg <= res_code;
        end
    end

    // Sleep and forced mode are terminal; no new event is produced once asleep.
    `PKGD_ASSERT_NEXT(a_asleep_sticky, asleep_reg, asleep_reg)
    `PKGD_ASSERT_SAME(a_sleep_needs_forced, asleep_reg, forced_mode_reg)
    `PKGD_ASSERT_SAME(a_silent_when_asleep, asleep_reg && advance, !res_valid)
    `PKGD_ASSERT_SAME(a_gate_holds_released, await_release_reg, !debounced_level_reg)

endmodule
